>>> sv/ledfm_pkg.sv
// shared types, codes and helpers for the two-channel led fader
package ledfm_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam logic [7:0] LEVEL_MAX = 8'd255;
    localparam logic [6:0] PERCENT_MAX = 7'd100;
    localparam int BLINK_TIMER_W = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_BLINK = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_TO   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TO     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_HALF  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_CYCLES = 3'd4;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_SET,
        CMD_BLINK,
        CMD_NOP,
        CMD_BAD
    } t_cmd;

    typedef enum logic [1:0] {
        FADE_IDLE,
        FADE_SETTLED,
        FADE_DOWN,
        FADE_UP
    } t_fade;

    typedef struct packed {
        t_cmd       cmd;
        logic       ch;
        logic [7:0] level;
        logic       motion;
    } t_entry;

    typedef struct packed {
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        logic       auto_active;
        logic       blinking;
        logic       status;
    } t_result;

    // clamp to 100 percent, then pct * 255 / 100 by reciprocal multiply
    function automatic logic [7:0] scale_percent(input logic [6:0] pct);
        logic [6:0]  clamped;
        logic [14:0] prod255;
        logic [27:0] prod;
        clamped = (pct > PERCENT_MAX) ? PERCENT_MAX : pct;
        prod255 = {clamped, 8'd0} - {8'd0, clamped};
        prod = {13'd0, prod255} * 28'd5243;
        return prod[26:19];
    endfunction

endpackage

>>> sv/ledfm_ifs.sv
// channel interfaces: command items, result items and configuration writes
interface ledfm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [1:0] channel;
    logic [6:0] level_percent;
    logic       motion;

    modport source(output valid, output opcode, output channel, output level_percent,
                   output motion, input ready);
    modport sink(input valid, input opcode, input channel, input level_percent,
                 input motion, output ready);
endinterface

interface ledfm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic       auto_active;
    logic       blinking;
    logic       status;

    modport source(output valid, output drive_a, output drive_b, output auto_active,
                   output blinking, output status, input ready);
    modport sink(input valid, input drive_a, input drive_b, input auto_active,
                 input blinking, input status, output ready);
endinterface

interface ledfm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

>>> sv/ledfm_front.sv
// front end: accepts command items and classifies them into queue entries
module ledfm_front (
    ledfm_in_if.sink           i_item,
    input  logic               i_full,
    output logic               o_push,
    output ledfm_pkg::t_entry  o_entry
);
    import ledfm_pkg::*;

    assign i_item.ready = !i_full;
    assign o_push = i_item.valid && !i_full;

    always_comb begin
        o_entry.ch = i_item.channel[0];
        o_entry.level = scale_percent(i_item.level_percent);
        o_entry.motion = i_item.motion;
        unique case (i_item.opcode)
            OP_TICK: begin
                o_entry.cmd = CMD_TICK;
            end
            OP_SET: begin
                o_entry.cmd = (i_item.channel < 2'(NUM_CHANNELS)) ? CMD_SET : CMD_BAD;
            end
            OP_BLINK: begin
                o_entry.cmd = CMD_BLINK;
            end
            default: begin
                o_entry.cmd = CMD_NOP;
            end
        endcase
    end

endmodule

>>> sv/ledfm_queue.sv
// short fifo of classified entries between front and back
module ledfm_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ledfm_pkg::t_entry  i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output ledfm_pkg::t_entry  o_entry
);
    import ledfm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count above depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count != '0))
        else $error("queue empty after push");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

>>> sv/ledfm_back.sv
// back end: fade, auto mode and blink show state, configuration and result register
module ledfm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ledfm_cfg_if.sink          i_cfg,
    input  logic               i_entry_valid,
    input  ledfm_pkg::t_entry  i_entry,
    output logic               o_pop,
    ledfm_out_if.source        o_result
);
    import ledfm_pkg::*;

    logic [15:0] r_fade_step;
    logic [23:0] r_motion_to;
    logic [23:0] r_idle_to;
    logic [9:0]  r_blink_half;
    logic [7:0]  r_blink_cycles;

    logic [7:0]  r_level_now [NUM_CHANNELS];
    logic [7:0]  r_level_target [NUM_CHANNELS];
    t_fade       r_fade_mode [NUM_CHANNELS];
    logic [7:0]  r_drive [NUM_CHANNELS];
    logic [15:0] r_fade_el;
    logic [23:0] r_motion_el;
    logic [23:0] r_idle_el;
    logic        r_auto_on;
    logic        r_motion_prev;
    logic        r_blink_pending;
    logic        r_show_run;
    logic [BLINK_TIMER_W-1:0] r_blink_timer;
    logic [7:0]  r_show_cycles;

    logic [7:0]  n_level_now [NUM_CHANNELS];
    logic [7:0]  n_level_target [NUM_CHANNELS];
    t_fade       n_fade_mode [NUM_CHANNELS];
    logic [7:0]  n_drive [NUM_CHANNELS];
    logic [15:0] n_fade_el;
    logic [23:0] n_motion_el;
    logic [23:0] n_idle_el;
    logic        n_auto_on;
    logic        n_motion_prev;
    logic        n_blink_pending;
    logic        n_show_run;
    logic [BLINK_TIMER_W-1:0] n_blink_timer;
    logic [7:0]  n_show_cycles;
    t_result     n_res;

    logic        r_out_valid;
    t_result     r_out;

    logic        go;
    logic        due;
    logic        stepped;
    logic        first_half;
    logic [BLINK_TIMER_W-1:0] timer_inc;
    logic [BLINK_TIMER_W-1:0] half_w;
    logic [7:0]  cycles_inc;

    assign go = i_entry_valid && (!r_out_valid || o_result.ready);
    assign o_pop = go;
    assign i_cfg.ready = 1'b1;
    assign half_w = BLINK_TIMER_W'(r_blink_half);

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            n_level_now[i] = r_level_now[i];
            n_level_target[i] = r_level_target[i];
            n_fade_mode[i] = r_fade_mode[i];
            n_drive[i] = r_drive[i];
        end
        n_fade_el = r_fade_el;
        n_motion_el = r_motion_el;
        n_idle_el = r_idle_el;
        n_auto_on = r_auto_on;
        n_motion_prev = r_motion_prev;
        n_blink_pending = r_blink_pending;
        n_show_run = r_show_run;
        n_blink_timer = r_blink_timer;
        n_show_cycles = r_show_cycles;
        due = 1'b0;
        stepped = 1'b0;
        timer_inc = r_blink_timer + 1'b1;
        cycles_inc = r_show_cycles + 1'b1;

        unique case (i_entry.cmd)
            CMD_TICK: begin
                n_fade_el = (r_fade_el == 16'hFFFF) ? r_fade_el : r_fade_el + 16'd1;
                n_motion_el = (r_motion_el == 24'hFFFFFF) ? r_motion_el : r_motion_el + 24'd1;
                n_idle_el = (r_idle_el == 24'hFFFFFF) ? r_idle_el : r_idle_el + 24'd1;
                if (r_show_run) begin
                    if (timer_inc >= {half_w[BLINK_TIMER_W-2:0], 1'b0}) begin
                        n_blink_timer = '0;
                        n_show_cycles = cycles_inc;
                        if (cycles_inc >= r_blink_cycles) begin
                            n_show_run = 1'b0;
                            n_show_cycles = '0;
                            for (int i = 0; i < NUM_CHANNELS; i++) begin
                                n_drive[i] = '0;
                            end
                        end
                    end else begin
                        n_blink_timer = timer_inc;
                    end
                end else begin
                    due = (n_fade_el >= r_fade_step);
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (r_fade_mode[i] == FADE_UP) begin
                            if (r_level_now[i] >= r_level_target[i]) begin
                                n_fade_mode[i] = FADE_SETTLED;
                            end else if (due) begin
                                n_level_now[i] = r_level_now[i] + 8'd1;
                                n_drive[i] = r_level_now[i] + 8'd1;
                                stepped = 1'b1;
                            end
                        end else if (r_fade_mode[i] == FADE_DOWN) begin
                            if (r_level_now[i] <= r_level_target[i]) begin
                                n_fade_mode[i] = FADE_SETTLED;
                            end else if (due) begin
                                n_level_now[i] = r_level_now[i] - 8'd1;
                                n_drive[i] = r_level_now[i] - 8'd1;
                                stepped = 1'b1;
                            end
                        end
                    end
                    if (stepped) begin
                        n_fade_el = '0;
                    end
                    if (r_auto_on) begin
                        if (n_motion_el >= r_motion_to) begin
                            n_motion_el = '0;
                            n_drive[1] = '0;
                            n_level_target[0] = '0;
                            n_fade_mode[0] = FADE_DOWN;
                        end
                        if (i_entry.motion && !r_motion_prev) begin
                            n_level_target[0] = LEVEL_MAX;
                            n_fade_mode[0] = (LEVEL_MAX > n_level_now[0]) ? FADE_UP : FADE_DOWN;
                            n_drive[1] = LEVEL_MAX;
                            n_motion_el = '0;
                        end
                    end
                    if (r_blink_pending) begin
                        n_blink_pending = 1'b0;
                        n_show_run = 1'b1;
                        n_blink_timer = '0;
                        n_show_cycles = '0;
                    end
                    if (n_idle_el >= r_idle_to) begin
                        n_idle_el = '0;
                        n_auto_on = 1'b1;
                    end
                    n_motion_prev = i_entry.motion;
                end
            end
            CMD_SET: begin
                n_auto_on = 1'b0;
                n_idle_el = '0;
                n_level_target[i_entry.ch] = i_entry.level;
                n_fade_mode[i_entry.ch] = (i_entry.level > r_level_now[i_entry.ch]) ?
                                          FADE_UP : FADE_DOWN;
            end
            CMD_BLINK: begin
                n_blink_pending = 1'b1;
            end
            default: begin
            end
        endcase

        first_half = (n_blink_timer < half_w);
        if (n_show_run) begin
            n_res.drive_a = first_half ? 8'd0 : LEVEL_MAX;
            n_res.drive_b = first_half ? LEVEL_MAX : 8'd0;
        end else begin
            n_res.drive_a = n_drive[0];
            n_res.drive_b = n_drive[1];
        end
        n_res.auto_active = n_auto_on;
        n_res.blinking = n_show_run;
        n_res.status = (i_entry.cmd == CMD_BAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_step <= 16'd15;
            r_motion_to <= 24'd30000;
            r_idle_to <= 24'd90000;
            r_blink_half <= 10'd100;
            r_blink_cycles <= 8'd31;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FADE_STEP:    r_fade_step <= i_cfg.data[15:0];
                CFG_MOTION_TO:    r_motion_to <= i_cfg.data;
                CFG_IDLE_TO:      r_idle_to <= i_cfg.data;
                CFG_BLINK_HALF:   r_blink_half <= i_cfg.data[9:0];
                CFG_BLINK_CYCLES: r_blink_cycles <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_level_now[i] <= '0;
                r_level_target[i] <= '0;
                r_fade_mode[i] <= FADE_IDLE;
                r_drive[i] <= '0;
            end
            r_fade_el <= '0;
            r_motion_el <= '0;
            r_idle_el <= '0;
            r_auto_on <= 1'b0;
            r_motion_prev <= 1'b0;
            r_blink_pending <= 1'b0;
            r_show_run <= 1'b0;
            r_blink_timer <= '0;
            r_show_cycles <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    r_level_now[i] <= n_level_now[i];
                    r_level_target[i] <= n_level_target[i];
                    r_fade_mode[i] <= n_fade_mode[i];
                    r_drive[i] <= n_drive[i];
                end
                r_fade_el <= n_fade_el;
                r_motion_el <= n_motion_el;
                r_idle_el <= n_idle_el;
                r_auto_on <= n_auto_on;
                r_motion_prev <= n_motion_prev;
                r_blink_pending <= n_blink_pending;
                r_show_run <= n_show_run;
                r_blink_timer <= n_blink_timer;
                r_show_cycles <= n_show_cycles;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= n_res;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.drive_a = r_out.drive_a;
    assign o_result.drive_b = r_out.drive_b;
    assign o_result.auto_active = r_out.auto_active;
    assign o_result.blinking = r_out.blinking;
    assign o_result.status = r_out.status;

    a_show_start_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_show_run) |-> !r_blink_pending)
        else $error("blink show started with request still pending");

    a_auto_start_clears_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_auto_on) |-> (r_idle_el == '0))
        else $error("auto mode entered without idle restart");

endmodule

>>> sv/two_channel_led_fader_motion_auto_core.sv
// top level of the two-channel led fader with motion auto mode and blink show
// The block takes one command item per clock while its queue has room and returns one result
// item for each, in order. The back end registers each result after its item leaves the queue;
// the sustained rate is one item per cycle while results are taken. A queue of QUEUE_DEPTH
// classified items lets the input keep flowing while a result waits to be taken. Configuration
// writes are taken on every cycle and should be issued only while no item is in flight.
module two_channel_led_fader_motion_auto_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ledfm_in_if.sink   i_item,
    ledfm_cfg_if.sink  i_cfg,
    ledfm_out_if.source o_result
);
    import ledfm_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   q_valid;
    t_entry front_entry;
    t_entry q_entry;

    ledfm_front u_front (
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    ledfm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    ledfm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .i_entry_valid (q_valid),
        .i_entry       (q_entry),
        .o_pop         (pop),
        .o_result      (o_result)
    );

endmodule

>>> test/two_channel_led_fader_motion_auto_core_tb.sv
// testbench for the two-channel led fader: per-item output prediction checked in order
module two_channel_led_fader_motion_auto_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ledfm_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int unsigned FADE_SAT = 32'h0000_FFFF;
    localparam int unsigned TIMER_SAT = 32'h00FF_FFFF;
    localparam int MAX_WAIT = 11;
    localparam int PRINT_LIMIT = 40;
    localparam int PHASE_ITEMS = 238;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ledfm_in_if item_if();
    ledfm_cfg_if cfg_if();
    ledfm_out_if res_if();

    two_channel_led_fader_motion_auto_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_item(item_if),
        .i_cfg(cfg_if),
        .o_result(res_if)
    );

    always #5 i_clk = ~i_clk;

    // settings as the block should hold them
    int unsigned step_ms_cfg = 15;
    int unsigned motion_to_cfg = 30000;
    int unsigned idle_to_cfg = 90000;
    int unsigned blink_half_cfg = 100;
    int unsigned blink_laps_cfg = 31;

    // fader state
    logic [7:0] lvl_now [NUM_CHANNELS] = '{default: 8'd0};
    logic [7:0] lvl_goal [NUM_CHANNELS] = '{default: 8'd0};
    logic [7:0] drive_lvl [NUM_CHANNELS] = '{default: 8'd0};
    t_fade fade_dir [NUM_CHANNELS] = '{default: FADE_IDLE};
    int unsigned fade_ms = 0;
    int unsigned motion_ms = 0;
    int unsigned idle_ms = 0;
    int unsigned show_ms = 0;
    int unsigned show_laps = 0;
    bit auto_on = 1'b0;
    bit motion_last = 1'b0;
    bit blink_queued = 1'b0;
    bit show_on = 1'b0;

    t_result led_outputs_due[$];
    int errors = 0;
    bit steady = 1'b0;

    function automatic int unsigned sat_up(int unsigned v, int unsigned top);
        return (v >= top) ? top : v + 1;
    endfunction

    function automatic void retarget(int ch, logic [7:0] goal);
        lvl_goal[ch] = goal;
        fade_dir[ch] = (goal > lvl_now[ch]) ? FADE_UP : FADE_DOWN;
    endfunction

    function automatic void advance_ms(logic motion);
        bit due;
        bit stepped;
        fade_ms = sat_up(fade_ms, FADE_SAT);
        motion_ms = sat_up(motion_ms, TIMER_SAT);
        idle_ms = sat_up(idle_ms, TIMER_SAT);
        if (show_on) begin
            show_ms++;
            if (show_ms >= 2 * blink_half_cfg) begin
                show_ms = 0;
                show_laps++;
                if (show_laps >= blink_laps_cfg) begin
                    show_on = 1'b0;
                    show_laps = 0;
                    drive_lvl = '{default: 8'd0};
                end
            end
            return;
        end
        due = (fade_ms >= step_ms_cfg);
        stepped = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            case (fade_dir[i])
                FADE_UP: begin
                    if (lvl_now[i] >= lvl_goal[i]) begin
                        fade_dir[i] = FADE_SETTLED;
                    end else if (due) begin
                        lvl_now[i] = lvl_now[i] + 8'd1;
                        drive_lvl[i] = lvl_now[i];
                        stepped = 1'b1;
                    end
                end
                FADE_DOWN: begin
                    if (lvl_now[i] <= lvl_goal[i]) begin
                        fade_dir[i] = FADE_SETTLED;
                    end else if (due) begin
                        lvl_now[i] = lvl_now[i] - 8'd1;
                        drive_lvl[i] = lvl_now[i];
                        stepped = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (stepped) fade_ms = 0;
        if (auto_on) begin
            if (motion_ms >= motion_to_cfg) begin
                motion_ms = 0;
                drive_lvl[1] = 8'd0;
                retarget(0, 8'd0);
            end
            if (motion && !motion_last) begin
                retarget(0, LEVEL_MAX);
                drive_lvl[1] = LEVEL_MAX;
                motion_ms = 0;
            end
        end
        if (blink_queued) begin
            blink_queued = 1'b0;
            show_on = 1'b1;
            show_ms = 0;
            show_laps = 0;
        end
        if (idle_ms >= idle_to_cfg) begin
            idle_ms = 0;
            auto_on = 1'b1;
        end
        motion_last = motion;
    endfunction

    function automatic t_result predict_outputs(logic [1:0] op, logic [1:0] ch,
                                                logic [6:0] pct, logic motion);
        t_result r;
        int unsigned pct_ok;
        bit first_half;
        r = '0;
        case (op)
            OP_TICK: advance_ms(motion);
            OP_SET: begin
                if (ch < NUM_CHANNELS) begin
                    pct_ok = (pct > 100) ? 100 : 32'(pct);
                    auto_on = 1'b0;
                    idle_ms = 0;
                    retarget(32'(ch), 8'(pct_ok * 255 / 100));
                end else begin
                    r.status = 1'b1;
                end
            end
            OP_BLINK: blink_queued = 1'b1;
            default: ;
        endcase
        if (show_on) begin
            first_half = (show_ms < blink_half_cfg);
            r.drive_a = first_half ? 8'd0 : LEVEL_MAX;
            r.drive_b = first_half ? LEVEL_MAX : 8'd0;
        end else begin
            r.drive_a = drive_lvl[0];
            r.drive_b = drive_lvl[1];
        end
        r.auto_active = auto_on;
        r.blinking = show_on;
        return r;
    endfunction

    task automatic report(string what);
        errors++;
        if (errors <= PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, what);
    endtask

    // prediction on accepted items and settings, comparison on accepted results
    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_FADE_STEP:    step_ms_cfg = 32'(cfg_if.data[15:0]);
                    CFG_MOTION_TO:    motion_to_cfg = 32'(cfg_if.data[23:0]);
                    CFG_IDLE_TO:      idle_to_cfg = 32'(cfg_if.data[23:0]);
                    CFG_BLINK_HALF:   blink_half_cfg = 32'(cfg_if.data[9:0]);
                    CFG_BLINK_CYCLES: blink_laps_cfg = 32'(cfg_if.data[7:0]);
                    default: ;
                endcase
            end
            if (item_if.valid && item_if.ready) begin
                led_outputs_due.push_back(predict_outputs(item_if.opcode, item_if.channel,
                                                          item_if.level_percent,
                                                          item_if.motion));
            end
            if (res_if.valid && res_if.ready) begin
                if (led_outputs_due.size() == 0) begin
                    report("result item with nothing expected");
                end else begin
                    want = led_outputs_due.pop_front();
                    if (res_if.drive_a !== want.drive_a)
                        report($sformatf("drive_a got %0d expected %0d",
                                         res_if.drive_a, want.drive_a));
                    if (res_if.drive_b !== want.drive_b)
                        report($sformatf("drive_b got %0d expected %0d",
                                         res_if.drive_b, want.drive_b));
                    if (res_if.auto_active !== want.auto_active)
                        report($sformatf("auto_active got %0b expected %0b",
                                         res_if.auto_active, want.auto_active));
                    if (res_if.blinking !== want.blinking)
                        report($sformatf("blinking got %0b expected %0b",
                                         res_if.blinking, want.blinking));
                    if (res_if.status !== want.status)
                        report($sformatf("status got %0b expected %0b",
                                         res_if.status, want.status));
                end
            end
        end
    end

    // result side stalls
    initial begin : take_results
        int stall;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
            repeat (stall) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    task automatic send_item(logic [1:0] op, logic [1:0] ch, logic [6:0] pct, logic motion);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
        repeat (gap) begin
            @(negedge i_clk);
            item_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        item_if.valid <= 1'b1;
        item_if.opcode <= op;
        item_if.channel <= ch;
        item_if.level_percent <= pct;
        item_if.motion <= motion;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
    endtask

    task automatic settle(int extra);
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (led_outputs_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_settings(int unsigned step, int unsigned motion_to,
                                  int unsigned idle_to, int unsigned half, int unsigned laps);
        settle(6);
        write_reg(CFG_FADE_STEP, CFG_DATA_W'(step));
        write_reg(CFG_MOTION_TO, CFG_DATA_W'(motion_to));
        write_reg(CFG_IDLE_TO, CFG_DATA_W'(idle_to));
        write_reg(CFG_BLINK_HALF, CFG_DATA_W'(half));
        write_reg(CFG_BLINK_CYCLES, CFG_DATA_W'(laps));
    endtask

    task automatic test_reset_defaults();
        send_item(OP_TICK, 2'd0, 7'd0, 1'b0);
        send_item(OP_SET, 2'd0, 7'd127, 1'b1);
        send_item(OP_TICK, 2'd3, 7'd127, 1'b1);
    endtask

    task automatic test_commands();
        write_settings(1, 3, 6, 1, 1);
        send_item(OP_SET, 2'd1, 7'd0, 1'b0);
        send_item(OP_SET, 2'd2, 7'd60, 1'b0);
        send_item(OP_SET, 2'd3, 7'd127, 1'b1);
        send_item(OP_NOP, 2'd3, 7'd127, 1'b1);
        send_item(OP_TICK, 2'd0, 7'd0, 1'b0);
        send_item(OP_SET, 2'd0, 7'd1, 1'b0);
        send_item(OP_TICK, 2'd0, 7'd0, 1'b0);
        send_item(OP_TICK, 2'd0, 7'd0, 1'b0);
    endtask

    task automatic test_auto_and_blink();
        write_settings(1, 1, 3, 1, 2);
        repeat (4) send_item(OP_TICK, 2'd0, 7'd0, 1'b0);
        // timeout and rising edge land on the same tick
        send_item(OP_TICK, 2'd0, 7'd0, 1'b1);
        send_item(OP_TICK, 2'd0, 7'd0, 1'b1);
        send_item(OP_BLINK, 2'd0, 7'd0, 1'b0);
        repeat (3) send_item(OP_TICK, 2'd0, 7'd0, 1'b0);
    endtask

    task automatic test_zero_registers();
        write_settings(0, 0, 0, 0, 0);
        send_item(OP_BLINK, 2'd1, 7'd10, 1'b0);
        repeat (3) send_item(OP_TICK, 2'd0, 7'd0, 1'b1);
        send_item(OP_SET, 2'd1, 7'd50, 1'b0);
        repeat (2) send_item(OP_TICK, 2'd0, 7'd0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int r;
        int set_weight;
        logic [1:0] op;
        logic [1:0] ch;
        logic [6:0] pct;
        logic mot;
        mot = 1'b0;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_settings(1, 1, 1, 1, 1);
                1: write_settings(FADE_SAT, TIMER_SAT, TIMER_SAT, 1023, 255);
                default: write_settings($urandom_range(1, 4), $urandom_range(1, 40),
                                        $urandom_range(1, 60), $urandom_range(1, 6),
                                        $urandom_range(1, 4));
            endcase
            set_weight = $urandom_range(1, 16);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 32 == 0) steady = ($urandom_range(0, 3) == 0);
                if (n == PHASE_ITEMS / 2) settle(0);
                r = $urandom_range(0, 99);
                ch = 2'($urandom_range(0, 3));
                pct = 7'($urandom_range(0, 127));
                if (r < set_weight) begin
                    op = OP_SET;
                    ch = ($urandom_range(0, 7) != 0) ? 2'($urandom_range(0, 1))
                                                     : 2'($urandom_range(2, 3));
                    pct = ($urandom_range(0, 7) != 0) ? 7'($urandom_range(0, 100))
                                                      : 7'($urandom_range(101, 127));
                end else if (r < set_weight + 2) begin
                    op = OP_BLINK;
                end else if (r < set_weight + 4) begin
                    op = OP_NOP;
                end else begin
                    op = OP_TICK;
                end
                if ($urandom_range(0, 5) == 0) mot = ~mot;
                send_item(op, ch, pct, mot);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.opcode = OP_TICK;
        item_if.channel = 2'd0;
        item_if.level_percent = 7'd0;
        item_if.motion = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_FADE_STEP;
        cfg_if.data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_commands();
        test_auto_and_blink();
        test_zero_registers();
        test_random_traffic();
        settle(8);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
